// ----- rtl/core/badf_pkg.sv -----
// Shared types, register indexes and reset values for the box average distance follower.
package badf_pkg;

  // Default saturation limit for the per-frame point count
  localparam int DEF_MAX_POINTS = 65536;
  // Depth of the frame queue between front and back
  localparam int DEF_QUEUE_DEPTH = 4;

  // Field widths
  localparam int COORD_W  = 16;
  localparam int MAG_W    = 15;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRONT_MIN     = 3'd0,
    REG_FRONT_MAX     = 3'd1,
    REG_SIDE_MIN      = 3'd2,
    REG_SIDE_MAX      = 3'd3,
    REG_GOAL_DISTANCE = 3'd4,
    REG_GOAL_MARGIN   = 3'd5,
    REG_DRIVE_SPEED   = 3'd6
  } reg_idx_t;

  // Register reset values
  localparam logic signed [COORD_W-1:0] RST_FRONT_MIN     = 16'sd300;
  localparam logic signed [COORD_W-1:0] RST_FRONT_MAX     = 16'sd5000;
  localparam logic signed [COORD_W-1:0] RST_SIDE_MIN      = -16'sd200;
  localparam logic signed [COORD_W-1:0] RST_SIDE_MAX      = 16'sd200;
  localparam logic signed [COORD_W-1:0] RST_GOAL_DISTANCE = 16'sd2000;
  localparam logic [MAG_W-1:0]          RST_GOAL_MARGIN   = 15'd200;
  localparam logic [MAG_W-1:0]          RST_DRIVE_SPEED   = 15'd256;

  // Configuration bundle seen by front and back
  typedef struct packed {
    logic signed [COORD_W-1:0] front_min;
    logic signed [COORD_W-1:0] front_max;
    logic signed [COORD_W-1:0] side_min;
    logic signed [COORD_W-1:0] side_max;
    logic signed [COORD_W-1:0] goal_distance;
    logic [MAG_W-1:0]          goal_margin;
    logic [MAG_W-1:0]          drive_speed;
  } cfg_t;

endpackage

// ----- rtl/core/badf_fifo.sv -----
// Small register queue carrying closed-frame totals from front to back.
module badf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = badf_pkg::DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OccW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [OccW-1:0] FullOcc = OccW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [OccW-1:0]  occ;

  assign full    = (occ == FullOcc);
  assign empty   = (occ == '0);
  assign rd_data = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        occ <= occ + 1'b1;
      end else if (pop && !push) begin
        occ <= occ - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= FullOcc)
    else $error("queue occupancy beyond depth");
`endif

endmodule

// ----- rtl/core/badf_front.sv -----
// Front end: accepts points, tests them against the box and accumulates the frame totals.
module badf_front #(
  parameter int MAX_POINTS = badf_pkg::DEF_MAX_POINTS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  badf_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [badf_pkg::COORD_W-1:0] point_forward,
  input  logic signed [badf_pkg::COORD_W-1:0] point_side,
  input  logic                                point_present,
  input  logic                                frame_end,
  input  logic                                queue_full,
  output logic                                push,
  output logic [$clog2(MAX_POINTS+1)+badf_pkg::COORD_W+$clog2(MAX_POINTS+1)-1:0] push_data
);

  localparam int CntW = $clog2(MAX_POINTS + 1);
  localparam int SumW = CntW + badf_pkg::COORD_W;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_POINTS);

  logic signed [SumW-1:0] forward_sum;
  logic signed [SumW-1:0] forward_sum_next;
  logic [CntW-1:0]        point_count;
  logic [CntW-1:0]        point_count_next;
  logic                   in_box;
  logic                   accept;

  // Room in the queue is needed only for a frame close, but stall uniformly
  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // Box test with saturation guard
  assign in_box = point_present
               && (point_forward >= cfg.front_min) && (point_forward <= cfg.front_max)
               && (point_side >= cfg.side_min) && (point_side <= cfg.side_max)
               && (point_count < MaxCnt);

  always_comb begin
    forward_sum_next = forward_sum;
    point_count_next = point_count;
    if (in_box) begin
      forward_sum_next = forward_sum + SumW'(point_forward);
      point_count_next = point_count + 1'b1;
    end
  end

  // Running totals, cleared when a frame closes
  always_ff @(posedge clk) begin
    if (rst) begin
      forward_sum <= '0;
      point_count <= '0;
    end else if (accept) begin
      if (frame_end) begin
        forward_sum <= '0;
        point_count <= '0;
      end else begin
        forward_sum <= forward_sum_next;
        point_count <= point_count_next;
      end
    end
  end

  // Closed frame goes to the queue, current point included
  assign push      = accept && frame_end;
  assign push_data = {forward_sum_next, point_count_next};

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst) point_count <= MaxCnt)
    else $error("point count above limit");
  a_clear_on_close: assert property (@(posedge clk) disable iff (rst)
    accept && frame_end |=> (point_count == '0) && (forward_sum == '0))
    else $error("totals not cleared after frame close");
  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !queue_full)
    else $error("frame pushed without queue room");
`endif

endmodule

// ----- rtl/core/badf_back.sv -----
// Back end: turns frame totals into a speed decision through product and compare stages.
module badf_back #(
  parameter int MAX_POINTS = badf_pkg::DEF_MAX_POINTS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  badf_pkg::cfg_t                      cfg,
  input  logic                                queue_empty,
  input  logic [$clog2(MAX_POINTS+1)+badf_pkg::COORD_W+$clog2(MAX_POINTS+1)-1:0] queue_data,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [badf_pkg::COORD_W-1:0] speed_command,
  output logic                                status
);

  localparam int CntW  = $clog2(MAX_POINTS + 1);
  localparam int SumW  = CntW + badf_pkg::COORD_W;
  localparam int ThrW  = badf_pkg::COORD_W + 1;
  localparam int ProdW = ThrW + CntW + 1;

  logic signed [SumW-1:0] q_sum;
  logic [CntW-1:0]        q_cnt;
  logic signed [CntW:0]   cnt_s;
  logic signed [ThrW-1:0] lo_thr;
  logic signed [ThrW-1:0] hi_thr;
  logic signed [ThrW-1:0] margin_s;

  logic                    a_valid;
  logic                    a_ready;
  logic                    a_empty;
  logic signed [SumW-1:0]  a_sum;
  logic signed [ProdW-1:0] a_p_lo;
  logic signed [ProdW-1:0] a_p_hi;
  logic signed [ProdW-1:0] a_p_fmin;
  logic signed [ProdW-1:0] a_p_fmax;

  logic                                b_ready;
  logic signed [ProdW-1:0]             sum_ext;
  logic signed [badf_pkg::COORD_W-1:0] speed_pos;
  logic signed [badf_pkg::COORD_W-1:0] speed_neg;
  logic signed [badf_pkg::COORD_W-1:0] speed_sel;

  assign {q_sum, q_cnt} = queue_data;
  assign cnt_s    = $signed({1'b0, q_cnt});
  assign margin_s = $signed({2'b00, cfg.goal_margin});
  assign lo_thr   = ThrW'(cfg.goal_distance) - margin_s;
  assign hi_thr   = ThrW'(cfg.goal_distance) + margin_s;

  // Pipeline handshake
  assign b_ready = !out_valid || out_ready;
  assign a_ready = !a_valid || b_ready;
  assign pop     = !queue_empty && a_ready;

  // Product stage: thresholds times count
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= !queue_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_empty  <= (q_cnt == '0);
      a_sum    <= q_sum;
      a_p_lo   <= lo_thr * cnt_s;
      a_p_hi   <= hi_thr * cnt_s;
      a_p_fmin <= cfg.front_min * cnt_s;
      a_p_fmax <= cfg.front_max * cnt_s;
    end
  end

  // Compare stage and output register
  assign sum_ext   = ProdW'(a_sum);
  assign speed_pos = $signed({1'b0, cfg.drive_speed});
  assign speed_neg = -speed_pos;

  always_comb begin
    if (a_empty) begin
      speed_sel = '0;
    end else if ((sum_ext <= a_p_lo) && (sum_ext >= a_p_fmin)) begin
      speed_sel = speed_neg;
    end else if ((sum_ext >= a_p_hi) && (sum_ext <= a_p_fmax)) begin
      speed_sel = speed_pos;
    end else begin
      speed_sel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_ready) begin
      speed_command <= speed_sel;
      status        <= a_empty;
    end
  end

`ifndef ASSERT_OFF
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> speed_command == '0)
    else $error("nonzero speed with nothing seen");
  a_speed_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (speed_command == '0) || (speed_command == speed_pos)
                  || (speed_command == speed_neg))
    else $error("speed not one of the three commands");
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !b_ready |=> a_valid && $stable(a_sum) && $stable(a_empty))
    else $error("product stage lost data while stalled");
`endif

endmodule

// ----- rtl/core/box_average_distance_follower_top.sv -----
// Top level of the box average distance follower: ports, configuration registers, front, queue, back.
//
// One point is accepted every clock cycle on the input stream while the queue has room, each
// frame being closed by an item with tlast set. Points inside the inclusive box add to a
// running forward sum and count in the front stage; the frame close pushes the totals into a
// four-entry queue, and the back end multiplies the thresholds by the count in one stage and
// compares in the next, registering the frame's speed command in the output register. The
// input stalls only when the queue is full, which needs a stalled output and a run of short
// frames. Configuration writes are always taken and must only happen while no frame is
// in flight.
module box_average_distance_follower_top #(
  parameter int MAX_POINTS  = badf_pkg::DEF_MAX_POINTS,
  parameter int QUEUE_DEPTH = badf_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,  // [15:0] point_forward, [31:16] point_side
  input  logic                              s_axis_tuser,  // [0] point_present
  input  logic                              s_axis_tlast,  // frame_end
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [15:0]                       m_axis_tdata,  // [15:0] speed_command
  output logic                              m_axis_tuser,  // [0] status
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [badf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                       cfg_data
);

  localparam int CntW   = $clog2(MAX_POINTS + 1);
  localparam int SumW   = CntW + badf_pkg::COORD_W;
  localparam int EntryW = SumW + CntW;

  badf_pkg::cfg_t cfg;

  logic              push;
  logic              pop;
  logic [EntryW-1:0] push_data;
  logic [EntryW-1:0] rd_data;
  logic              queue_full;
  logic              queue_empty;
  logic signed [badf_pkg::COORD_W-1:0] speed_command;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.front_min     <= badf_pkg::RST_FRONT_MIN;
      cfg.front_max     <= badf_pkg::RST_FRONT_MAX;
      cfg.side_min      <= badf_pkg::RST_SIDE_MIN;
      cfg.side_max      <= badf_pkg::RST_SIDE_MAX;
      cfg.goal_distance <= badf_pkg::RST_GOAL_DISTANCE;
      cfg.goal_margin   <= badf_pkg::RST_GOAL_MARGIN;
      cfg.drive_speed   <= badf_pkg::RST_DRIVE_SPEED;
    end else if (cfg_valid && cfg_ready) begin
      case (badf_pkg::reg_idx_t'(cfg_index))
        badf_pkg::REG_FRONT_MIN:     cfg.front_min     <= cfg_data;
        badf_pkg::REG_FRONT_MAX:     cfg.front_max     <= cfg_data;
        badf_pkg::REG_SIDE_MIN:      cfg.side_min      <= cfg_data;
        badf_pkg::REG_SIDE_MAX:      cfg.side_max      <= cfg_data;
        badf_pkg::REG_GOAL_DISTANCE: cfg.goal_distance <= cfg_data;
        badf_pkg::REG_GOAL_MARGIN:   cfg.goal_margin   <= cfg_data[badf_pkg::MAG_W-1:0];
        badf_pkg::REG_DRIVE_SPEED:   cfg.drive_speed   <= cfg_data[badf_pkg::MAG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  badf_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .point_forward (s_axis_tdata[15:0]),
    .point_side    (s_axis_tdata[31:16]),
    .point_present (s_axis_tuser),
    .frame_end     (s_axis_tlast),
    .queue_full    (queue_full),
    .push          (push),
    .push_data     (push_data)
  );

  badf_fifo #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (rd_data),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  badf_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .queue_empty   (queue_empty),
    .queue_data    (rd_data),
    .pop           (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .speed_command (speed_command),
    .status        (m_axis_tuser)
  );

  assign m_axis_tdata = speed_command;

endmodule
